// ===== sv/cwag_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwag_pkg
// Shared widths, register indexes and controller/datapath types for the
// 3D convolution window address generator.
// ----------------------------------------------------------------------------
package cwag_pkg;

    localparam int MAX_DIM_DEF = 256;

    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int STRIDE_W   = 5;
    localparam int HALF_W     = 3;
    localparam int IDX_W      = 24;
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // coord * stride
    localparam int PROD_W = COORD_W + STRIDE_W;
    // size_x * size_y
    localparam int SXY_W  = 2 * SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Z = 3'd6;

    typedef struct packed {
        logic load;  // capture coordinates
        logic prod;  // coord * stride per axis
        logic chk;   // bounds check, row offset, plane size
        logic pln;   // plane offset
        logic base;  // first index of window
        logic emit;  // send current word, advance walk
        logic err;   // send error word
    } t_dp_cmd;

    typedef struct packed {
        logic fits;
        logic last;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== sv/cwag_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwag channel interfaces
// Valid/ready channels for coordinates in, window words out, and
// register writes.
// ----------------------------------------------------------------------------
interface cwag_in_if;
    logic                         valid;
    logic                         ready;
    logic [cwag_pkg::COORD_W-1:0] out_x;
    logic [cwag_pkg::COORD_W-1:0] out_y;
    logic [cwag_pkg::COORD_W-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

interface cwag_out_if;
    logic                       valid;
    logic                       ready;
    logic [cwag_pkg::IDX_W-1:0] input_index;
    logic [cwag_pkg::POS_W-1:0] kernel_pos;
    logic                       last;
    logic                       out_of_range;

    modport source (output valid, output input_index, output kernel_pos, output last,
                    output out_of_range, input ready);
    modport sink   (input valid, input input_index, input kernel_pos, input last,
                    input out_of_range, output ready);
endinterface

interface cwag_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cwag_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [cwag_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/cwag_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwag_ctrl
// Sequencer: setup steps for one voxel, then the result walk, and the
// output valid flag.
// ----------------------------------------------------------------------------
module cwag_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    input  wire cwag_pkg::t_dp_sts i_sts,
    output cwag_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_CHK,
        S_PLN,
        S_BASE,
        S_EMIT,
        S_ERR
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_free;

    // output slot free when empty or being taken this cycle
    assign w_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_PLN;
            end
            S_PLN: begin
                o_cmd.pln = 1'b1;
                n_state   = i_sts.fits ? S_BASE : S_ERR;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (w_free) begin
                    o_cmd.err   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== sv/cwag_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwag_datapath
// Config registers, window base arithmetic, window walk counters and the
// output word register.
// ----------------------------------------------------------------------------
module cwag_datapath #(
    parameter int MAX_DIM = cwag_pkg::MAX_DIM_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [cwag_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cwag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [cwag_pkg::COORD_W-1:0]    i_out_x,
    input  wire logic [cwag_pkg::COORD_W-1:0]    i_out_y,
    input  wire logic [cwag_pkg::COORD_W-1:0]    i_out_z,
    input  wire cwag_pkg::t_dp_cmd               i_cmd,
    output cwag_pkg::t_dp_sts                    o_sts,
    output logic [cwag_pkg::IDX_W-1:0]           o_input_index,
    output logic [cwag_pkg::POS_W-1:0]           o_kernel_pos,
    output logic                                 o_last,
    output logic                                 o_out_of_range
);

    localparam int PROD_W = cwag_pkg::PROD_W;
    localparam int SIZE_W = cwag_pkg::SIZE_W;
    localparam int SXY_W  = cwag_pkg::SXY_W;
    localparam int IDX_W  = cwag_pkg::IDX_W;
    localparam int POS_W  = cwag_pkg::POS_W;
    localparam int ROW_W  = PROD_W + SIZE_W;
    localparam int PL_W   = PROD_W + SXY_W;

    logic [SIZE_W-1:0]             r_size_x, r_size_y, r_size_z;
    logic [cwag_pkg::HALF_W-1:0]   r_half;
    logic [cwag_pkg::STRIDE_W-1:0] r_stride_x, r_stride_y, r_stride_z;

    logic [cwag_pkg::COORD_W-1:0]  r_ox, r_oy, r_oz;
    logic [PROD_W-1:0]             r_prod_x, r_prod_y, r_prod_z;
    logic [SXY_W-1:0]              r_sxy;
    logic [ROW_W-1:0]              r_rowoff;
    logic [IDX_W-1:0]              r_planeoff;
    logic                          r_fits;

    logic [IDX_W-1:0]              r_plane, r_row, r_idx;
    logic [1:0]                    r_dx, r_dy, r_dz;
    logic [POS_W-1:0]              r_pos;

    logic [IDX_W-1:0]              r_o_index;
    logic [POS_W-1:0]              r_o_pos;
    logic                          r_o_last, r_o_oor;

    logic             w_hx, w_hy, w_hz;
    logic [1:0]       w_ex, w_ey, w_ez;
    logic [PROD_W:0]  w_end_x, w_end_y, w_end_z;
    logic             w_fit_x, w_fit_y, w_fit_z;
    logic [PL_W-1:0]  w_plane_full;
    logic [IDX_W-1:0] w_sx, w_sxy, w_next_row, w_next_plane;
    logic             w_last;

    assign w_hx = r_half[0];
    assign w_hy = r_half[1];
    assign w_hz = r_half[2];
    assign w_ex = {w_hx, 1'b0};
    assign w_ey = {w_hy, 1'b0};
    assign w_ez = {w_hz, 1'b0};

    // window end = coord*stride + 2*half, must stay below the size
    assign w_end_x = {1'b0, r_prod_x} + (PROD_W+1)'(w_ex);
    assign w_end_y = {1'b0, r_prod_y} + (PROD_W+1)'(w_ey);
    assign w_end_z = {1'b0, r_prod_z} + (PROD_W+1)'(w_ez);

    assign w_fit_x = (r_size_x != '0) && (32'(r_size_x) <= 32'(MAX_DIM))
                     && (w_end_x < (PROD_W+1)'(r_size_x));
    assign w_fit_y = (r_size_y != '0) && (32'(r_size_y) <= 32'(MAX_DIM))
                     && (w_end_y < (PROD_W+1)'(r_size_y));
    assign w_fit_z = (r_size_z != '0) && (32'(r_size_z) <= 32'(MAX_DIM))
                     && (w_end_z < (PROD_W+1)'(r_size_z));

    assign w_plane_full = PL_W'(r_prod_z) * PL_W'(r_sxy);

    assign w_sx         = IDX_W'(r_size_x);
    assign w_sxy        = IDX_W'(r_sxy);
    assign w_next_row   = r_row + w_sx;
    assign w_next_plane = r_plane + w_sxy;
    assign w_last       = (r_dx == w_ex) && (r_dy == w_ey) && (r_dz == w_ez);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x   <= SIZE_W'(1);
            r_size_y   <= SIZE_W'(1);
            r_size_z   <= SIZE_W'(1);
            r_half     <= '0;
            r_stride_x <= cwag_pkg::STRIDE_W'(1);
            r_stride_y <= cwag_pkg::STRIDE_W'(1);
            r_stride_z <= cwag_pkg::STRIDE_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cwag_pkg::REG_SIZE_X:   r_size_x   <= i_cfg_data;
                cwag_pkg::REG_SIZE_Y:   r_size_y   <= i_cfg_data;
                cwag_pkg::REG_SIZE_Z:   r_size_z   <= i_cfg_data;
                cwag_pkg::REG_HALF:     r_half     <= i_cfg_data[cwag_pkg::HALF_W-1:0];
                cwag_pkg::REG_STRIDE_X: r_stride_x <= i_cfg_data[cwag_pkg::STRIDE_W-1:0];
                cwag_pkg::REG_STRIDE_Y: r_stride_y <= i_cfg_data[cwag_pkg::STRIDE_W-1:0];
                cwag_pkg::REG_STRIDE_Z: r_stride_z <= i_cfg_data[cwag_pkg::STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ox <= i_out_x;
            r_oy <= i_out_y;
            r_oz <= i_out_z;
        end
        if (i_cmd.prod) begin
            r_prod_x <= PROD_W'(r_ox) * PROD_W'(r_stride_x);
            r_prod_y <= PROD_W'(r_oy) * PROD_W'(r_stride_y);
            r_prod_z <= PROD_W'(r_oz) * PROD_W'(r_stride_z);
        end
        if (i_cmd.chk) begin
            r_fits   <= w_fit_x && w_fit_y && w_fit_z;
            r_rowoff <= ROW_W'(r_prod_y) * ROW_W'(r_size_x);
            r_sxy    <= SXY_W'(r_size_x) * SXY_W'(r_size_y);
        end
        if (i_cmd.pln) begin
            r_planeoff <= w_plane_full[IDX_W-1:0];
        end
        if (i_cmd.base) begin
            r_plane <= r_planeoff + IDX_W'(r_rowoff) + IDX_W'(r_prod_x);
            r_row   <= r_planeoff + IDX_W'(r_rowoff) + IDX_W'(r_prod_x);
            r_idx   <= r_planeoff + IDX_W'(r_rowoff) + IDX_W'(r_prod_x);
            r_dx    <= '0;
            r_dy    <= '0;
            r_dz    <= '0;
            r_pos   <= '0;
        end
        if (i_cmd.emit) begin
            r_o_index <= r_idx;
            r_o_pos   <= r_pos;
            r_o_last  <= w_last;
            r_o_oor   <= 1'b0;
            r_pos     <= r_pos + POS_W'(1);
            // x innermost, then y, then z
            if (r_dx != w_ex) begin
                r_dx  <= r_dx + 2'd1;
                r_idx <= r_idx + IDX_W'(1);
            end else if (r_dy != w_ey) begin
                r_dx  <= '0;
                r_dy  <= r_dy + 2'd1;
                r_row <= w_next_row;
                r_idx <= w_next_row;
            end else begin
                r_dx    <= '0;
                r_dy    <= '0;
                r_dz    <= r_dz + 2'd1;
                r_plane <= w_next_plane;
                r_row   <= w_next_plane;
                r_idx   <= w_next_plane;
            end
        end
        if (i_cmd.err) begin
            r_o_index <= '0;
            r_o_pos   <= '0;
            r_o_last  <= 1'b1;
            r_o_oor   <= 1'b1;
        end
    end

    assign o_sts.fits     = r_fits;
    assign o_sts.last     = w_last;
    assign o_input_index  = r_o_index;
    assign o_kernel_pos   = r_o_pos;
    assign o_last         = r_o_last;
    assign o_out_of_range = r_o_oor;

endmodule
`default_nettype wire

// ===== sv/conv3d_window_address_gen_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// conv3d_window_address_gen_unit
// Strided 3D convolution window address generator: one output voxel in,
// the linear input index of every window voxel out.
// ----------------------------------------------------------------------------
//  channel    dir  modport  words
//  i_cfg_ch   in   sink     reg_index (0..6), data; always ready
//  i_in_ch    in   sink     out_x, out_y, out_z; one per voxel
//  o_out_ch   out  source   input_index, kernel_pos, last, out_of_range
//
//  Per voxel: setup steps (products, bounds check, plane offset, base), then
//  one word per cycle while the sink is ready, 1, 3, 9 or 27 words; next
//  voxel taken after the last word is loaded.
//  Out-of-range window: setup steps (products, bounds check, plane offset),
//  then one error word.
//  Reset is synchronous; registers return to sizes 1, half 0, strides 1.
//  Output is registered; a stalled sink holds the walk at its current word.
// ----------------------------------------------------------------------------
module conv3d_window_address_gen_unit #(
    parameter int MAX_DIM = cwag_pkg::MAX_DIM_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    cwag_cfg_if.sink   i_cfg_ch,
    cwag_in_if.sink    i_in_ch,
    cwag_out_if.source o_out_ch
);

    cwag_pkg::t_dp_cmd w_cmd;
    cwag_pkg::t_dp_sts w_sts;

    assign i_cfg_ch.ready = 1'b1;

    cwag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cwag_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_ch.valid),
        .i_cfg_index    (i_cfg_ch.reg_index),
        .i_cfg_data     (i_cfg_ch.data),
        .i_out_x        (i_in_ch.out_x),
        .i_out_y        (i_in_ch.out_y),
        .i_out_z        (i_in_ch.out_z),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_input_index  (o_out_ch.input_index),
        .o_kernel_pos   (o_out_ch.kernel_pos),
        .o_last         (o_out_ch.last),
        .o_out_of_range (o_out_ch.out_of_range)
    );

endmodule
`default_nettype wire

// ===== sv/cwag_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwag_checker
// Port-level checks for the window address generator, bound to the top.
// ----------------------------------------------------------------------------
module cwag_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [cwag_pkg::IDX_W-1:0]   i_index,
    input wire logic [cwag_pkg::POS_W-1:0]   i_pos,
    input wire logic                         i_last,
    input wire logic                         i_oor
);

    // a word waiting at the output stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // error word is the single, final, zeroed word of its voxel
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_oor |-> i_last && (i_index == '0) && (i_pos == '0))
        else $error("malformed out-of-range word");

    // window is at most 3x3x3
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pos <= cwag_pkg::POS_W'(26)))
        else $error("kernel position beyond window");

    // one voxel in flight: no new coordinate right after one is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("coordinate taken while busy");

endmodule

bind conv3d_window_address_gen_unit cwag_checker u_cwag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_index     (o_out_ch.input_index),
    .i_pos       (o_out_ch.kernel_pos),
    .i_last      (o_out_ch.last),
    .i_oor       (o_out_ch.out_of_range)
);
`default_nettype wire
